// ===== rtl/edf_ts_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the deadline scheduler.
// Used by the scan, the top level and the bench; depends on nothing.
package edf_ts_pkg;

  localparam int TASK_SLOTS = 32;
  localparam int TIME_BITS  = 48;
  localparam int SLOT_BITS  = $clog2(TASK_SLOTS);
  localparam int CNT_BITS   = $clog2(TASK_SLOTS + 1);
  localparam int ID_BITS    = 5;
  localparam int KIND_BITS  = 3;

  localparam logic [KIND_BITS-1:0] KIND_REGISTER = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_READY    = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_UNREADY  = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_REMOVE   = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_QUERY    = 3'd4;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_UNKNOWN = 1'b1;

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic [ID_BITS-1:0]   task_id;
    logic [TIME_BITS-1:0] relative_deadline;
    logic [TIME_BITS-1:0] now;
    logic                 exited;
    logic [ID_BITS-1:0]   current_id;
    logic                 current_is_edf;
  } in_t;

  typedef struct packed {
    logic                status;
    logic                next_valid;
    logic [ID_BITS-1:0]  next_task;
    logic                preempt;
    logic [CNT_BITS-1:0] ready_count;
  } out_t;

  typedef struct packed {
    logic                 clr;
    logic                 en;
    logic                 rdy;
    logic [SLOT_BITS-1:0] slot;
  } scan_ctl_t;

  typedef struct packed {
    logic                 found;
    logic [SLOT_BITS-1:0] slot;
    logic [TIME_BITS-1:0] dl;
  } scan_res_t;

endpackage

// ===== rtl/edf_ts_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and one registered read port.
// Stands alone; holds no reset.
module edf_ts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/edf_ts_scan.sv =====
`timescale 1ns / 1ps
// Running minimum over deadlines streamed out of the deadline memory.
// Depends on edf_ts_pkg for the control and result structs.
module edf_ts_scan (
  input  logic                               clk,
  input  logic                               rst_n,
  input  edf_ts_pkg::scan_ctl_t              ctl,
  input  logic [edf_ts_pkg::TIME_BITS-1:0]   rd_data,
  output edf_ts_pkg::scan_res_t              res
);
  import edf_ts_pkg::*;

  logic                 found_r, found_nxt;
  logic [SLOT_BITS-1:0] slot_r, slot_nxt;
  logic [TIME_BITS-1:0] dl_r, dl_nxt;

  always_comb begin
    found_nxt = found_r;
    slot_nxt  = slot_r;
    dl_nxt    = dl_r;
    if (ctl.clr) begin
      found_nxt = 1'b0;
      slot_nxt  = '0;
    end else if (ctl.en && ctl.rdy && (!found_r || (rd_data < dl_r))) begin
      found_nxt = 1'b1;
      slot_nxt  = ctl.slot;
      dl_nxt    = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      slot_r  <= '0;
    end else begin
      found_r <= found_nxt;
      slot_r  <= slot_nxt;
    end
    dl_r <= dl_nxt;
  end

  assign res = '{found: found_r, slot: slot_r, dl: dl_r};

endmodule

// ===== rtl/edf_task_scheduler.sv =====
`timescale 1ns / 1ps
// Earliest-deadline-first task table: sequencer, slot flags and top level.
// Depends on edf_ts_pkg, edf_ts_ram and edf_ts_scan.
// Sequence: accept, apply, a deadline scan reading one slot per cycle from the
// deadline memory, a read of the current task's deadline, the compare and the
// registered result strobe. A beat is taken only in idle; results are never stalled.
// Reset clears the flags and the ready count; registration writes a deadline before use.
module edf_task_scheduler (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  edf_ts_pkg::in_t   in_item,
  output logic              out_strobe,
  output edf_ts_pkg::out_t  out_item
);
  import edf_ts_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_APPLY = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_CUR   = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;

  logic [2:0]            state_r, state_nxt;
  in_t                   in_r;
  logic [TASK_SLOTS-1:0] reg_r, reg_nxt;
  logic [TASK_SLOTS-1:0] rdy_r, rdy_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [SLOT_BITS-1:0]  addr_r, addr_nxt;
  logic                  rd_pend_r;
  logic [SLOT_BITS-1:0]  rd_slot_r;
  logic                  status_r, status_nxt;
  out_t                  out_r, out_nxt;
  logic                  out_strobe_r;

  logic                  known;
  logic [TIME_BITS:0]    dl_sum;
  logic [TIME_BITS-1:0]  dl_sat;
  logic                  we;
  logic [TIME_BITS-1:0]  wdata;
  logic [SLOT_BITS-1:0]  raddr;
  logic [TIME_BITS-1:0]  rdata;
  logic                  preempt;
  scan_ctl_t             scan_ctl;
  scan_res_t             scan_res;

  assign known  = ({1'b0, in_r.task_id} < (ID_BITS + 1)'(TASK_SLOTS)) && reg_r[in_r.task_id];
  assign dl_sum = {1'b0, in_r.now} + {1'b0, in_r.relative_deadline};
  assign dl_sat = dl_sum[TIME_BITS] ? '1 : dl_sum[TIME_BITS-1:0];

  always_comb begin
    state_nxt  = state_r;
    reg_nxt    = reg_r;
    rdy_nxt    = rdy_r;
    cnt_nxt    = cnt_r;
    addr_nxt   = addr_r;
    status_nxt = status_r;
    we         = 1'b0;
    wdata      = '0;
    raddr      = addr_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        status_nxt = STATUS_DONE;
        addr_nxt   = '0;
        state_nxt  = S_SCAN;
        unique case (in_r.kind) inside
          KIND_REGISTER: begin
            if (!known && ({1'b0, in_r.task_id} < (ID_BITS + 1)'(TASK_SLOTS))) begin
              reg_nxt[in_r.task_id] = 1'b1;
              we                    = 1'b1;
              wdata                 = '0;
            end
          end
          KIND_READY: begin
            if (!known) begin
              status_nxt = STATUS_UNKNOWN;
            end else begin
              we    = 1'b1;
              wdata = dl_sat;
              if (!rdy_r[in_r.task_id]) begin
                rdy_nxt[in_r.task_id] = 1'b1;
                cnt_nxt               = cnt_r + CNT_BITS'(1);
              end
            end
          end
          KIND_UNREADY, KIND_REMOVE: begin
            if (!known) begin
              status_nxt = STATUS_UNKNOWN;
            end else begin
              if (rdy_r[in_r.task_id]) begin
                rdy_nxt[in_r.task_id] = 1'b0;
                cnt_nxt               = cnt_r - CNT_BITS'(1);
              end
              if (in_r.exited || (in_r.kind == KIND_REMOVE)) begin
                reg_nxt[in_r.task_id] = 1'b0;
              end
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        raddr    = addr_r;
        addr_nxt = addr_r + SLOT_BITS'(1);
        if (addr_r == SLOT_BITS'(TASK_SLOTS - 1)) begin
          state_nxt = S_CUR;
        end
      end
      S_CUR: begin
        raddr     = in_r.current_id[SLOT_BITS-1:0];
        state_nxt = S_CMP;
      end
      S_CMP: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign scan_ctl = '{clr: (state_r == S_APPLY), en: rd_pend_r, rdy: rdy_r[rd_slot_r],
                      slot: rd_slot_r};

  assign preempt = (in_r.kind == KIND_QUERY) &&
                   (!in_r.current_is_edf ||
                    (scan_res.found &&
                     ({1'b0, in_r.current_id} < (ID_BITS + 1)'(TASK_SLOTS)) &&
                     reg_r[in_r.current_id] && (scan_res.dl < rdata)));

  always_comb begin
    out_nxt = out_r;
    if (state_r == S_CMP) begin
      out_nxt.status      = status_r;
      out_nxt.next_valid  = scan_res.found;
      out_nxt.next_task   = ID_BITS'(scan_res.slot);
      out_nxt.preempt     = preempt;
      out_nxt.ready_count = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      reg_r        <= '0;
      rdy_r        <= '0;
      cnt_r        <= '0;
      rd_pend_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      reg_r        <= reg_nxt;
      rdy_r        <= rdy_nxt;
      cnt_r        <= cnt_nxt;
      rd_pend_r    <= (state_r == S_SCAN);
      out_strobe_r <= (state_r == S_CMP);
    end
    if ((state_r == S_IDLE) && start) begin
      in_r <= in_item;
    end
    addr_r    <= addr_nxt;
    rd_slot_r <= addr_r;
    status_r  <= status_nxt;
    out_r     <= out_nxt;
  end

  edf_ts_ram #(
    .WIDTH(TIME_BITS),
    .DEPTH(TASK_SLOTS)
  ) u_dl_ram (
    .clk  (clk),
    .we   (we),
    .waddr(in_r.task_id[SLOT_BITS-1:0]),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  edf_ts_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (scan_ctl),
    .rd_data(rdata),
    .res    (scan_res)
  );

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(rdy_r) == int'(cnt_r))
    else $error("ready count differs from the number of ready flags");

  a_ready_registered: assert property (@(posedge clk) disable iff (!rst_n)
    (rdy_r & ~reg_r) == '0)
    else $error("a ready slot is not registered");

  a_strobe_after_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == S_CMP))
    else $error("result strobe without a finished scan");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not start the sequencer");

endmodule

// ===== test/tb_edf_task_scheduler.sv =====
`timescale 1ns / 1ps
// Testbench for edf_task_scheduler: directed and random task-table operations, each
// result beat checked against a deadline-table predictor kept inside the bench.
// Depends on edf_ts_pkg and the scheduler RTL.
module tb_edf_task_scheduler;
  import edf_ts_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 12;
  localparam int GAP_MAX       = 13;
  localparam int DRAIN_CYCLES  = 40;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_BEATS  = 1900;
  localparam int STRETCH_BEATS = 100;
  localparam int DRAIN_EVERY   = 400;

  localparam logic [KIND_BITS-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [KIND_BITS-1:0] KIND_SPARE_LAST  = 3'd7;
  localparam logic [TIME_BITS-1:0] TIME_TOP         = {TIME_BITS{1'b1}};
  localparam logic [ID_BITS-1:0]   ID_TOP           = {ID_BITS{1'b1}};

  logic clk     = 1'b0;
  logic rst_n   = 1'b0;
  logic start   = 1'b0;
  in_t  in_item = '0;
  logic busy;
  logic out_strobe;
  out_t out_item;

  logic                 task_known    [TASK_SLOTS];
  logic                 task_ready    [TASK_SLOTS];
  logic [TIME_BITS-1:0] task_deadline [TASK_SLOTS];
  int unsigned          ready_tasks;

  out_t                 pending_results [$];
  out_t                 oldest_result;
  int unsigned          error_count = 0;
  int unsigned          cycle_count = 0;
  bit                   idle_on     = 1'b1;
  logic [TIME_BITS-1:0] sim_now     = '0;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  edf_task_scheduler i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  function automatic out_t apply_sched_op(input in_t it);
    out_t               res;
    logic [TIME_BITS:0] sum;
    logic               found;
    logic [ID_BITS-1:0] best;
    res        = '0;
    res.status = STATUS_DONE;
    case (it.kind) inside
      KIND_REGISTER: begin
        if (!task_known[it.task_id]) begin
          task_known[it.task_id]    = 1'b1;
          task_ready[it.task_id]    = 1'b0;
          task_deadline[it.task_id] = '0;
        end
      end
      KIND_READY: begin
        if (!task_known[it.task_id]) begin
          res.status = STATUS_UNKNOWN;
        end else begin
          sum = {1'b0, it.now} + {1'b0, it.relative_deadline};
          task_deadline[it.task_id] = sum[TIME_BITS] ? TIME_TOP : sum[TIME_BITS-1:0];
          if (!task_ready[it.task_id]) begin
            task_ready[it.task_id] = 1'b1;
            ready_tasks++;
          end
        end
      end
      KIND_UNREADY, KIND_REMOVE: begin
        if (!task_known[it.task_id]) begin
          res.status = STATUS_UNKNOWN;
        end else begin
          if (task_ready[it.task_id]) begin
            task_ready[it.task_id] = 1'b0;
            ready_tasks--;
          end
          if (it.kind == KIND_REMOVE || it.exited) begin
            task_known[it.task_id] = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    found = 1'b0;
    best  = '0;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      if (task_ready[i] && (!found || task_deadline[i] < task_deadline[best])) begin
        best  = ID_BITS'(i);
        found = 1'b1;
      end
    end
    res.next_valid = found;
    res.next_task  = best;
    if (it.kind == KIND_QUERY) begin
      if (!it.current_is_edf) begin
        res.preempt = 1'b1;
      end else if (found && task_known[it.current_id] &&
                   task_deadline[best] < task_deadline[it.current_id]) begin
        res.preempt = 1'b1;
      end
    end
    res.ready_count = CNT_BITS'(ready_tasks);
    return res;
  endfunction

  function automatic in_t make_item(input logic [KIND_BITS-1:0] kind,
                                    input logic [ID_BITS-1:0] id,
                                    input logic [TIME_BITS-1:0] rel,
                                    input logic [TIME_BITS-1:0] now,
                                    input logic dead,
                                    input logic [ID_BITS-1:0] cur,
                                    input logic edf);
    in_t it;
    it.kind              = kind;
    it.task_id           = id;
    it.relative_deadline = rel;
    it.now               = now;
    it.exited            = dead;
    it.current_id        = cur;
    it.current_is_edf    = edf;
    return it;
  endfunction

  function automatic in_t random_item();
    in_t         it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      it.kind = KIND_REGISTER;
    end else if (pick < 48) begin
      it.kind = KIND_READY;
    end else if (pick < 62) begin
      it.kind = KIND_UNREADY;
    end else if (pick < 72) begin
      it.kind = KIND_REMOVE;
    end else if (pick < 94) begin
      it.kind = KIND_QUERY;
    end else begin
      it.kind = KIND_BITS'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
    end
    it.task_id = ID_BITS'($urandom_range(0, TASK_SLOTS - 1));
    sim_now    = sim_now + TIME_BITS'($urandom_range(0, 2000));
    it.now     = sim_now;
    case ($urandom_range(0, 9))
      0: begin
        it.now               = TIME_BITS'({$urandom, $urandom});
        it.relative_deadline = TIME_BITS'({$urandom, $urandom});
      end
      1: it.relative_deadline = TIME_TOP - TIME_BITS'($urandom_range(0, 3));
      2: it.relative_deadline = TIME_BITS'($urandom_range(0, 3));
      default: it.relative_deadline = TIME_BITS'($urandom_range(0, 50000));
    endcase
    it.exited         = ($urandom_range(0, 9) < 3);
    it.current_id     = ID_BITS'($urandom_range(0, TASK_SLOTS - 1));
    it.current_is_edf = ($urandom_range(0, 9) < 8);
    return it;
  endfunction

  task automatic report_mismatch(input string field, input logic [TIME_BITS-1:0] got,
                                 input logic [TIME_BITS-1:0] want);
    $display("mismatch in %s at cycle %0d: got %0h, expected %0h",
             field, cycle_count, got, want);
    error_count++;
  endtask

  task automatic send_beat(input in_t it);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, GAP_MAX) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(apply_sched_op(it));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() > 0);
  endtask

  task automatic test_empty_table();
    send_beat(make_item(KIND_QUERY, '0, '0, '0, 1'b0, '0, 1'b1));
    send_beat(make_item(KIND_QUERY, '0, '0, '0, 1'b0, ID_TOP, 1'b0));
    send_beat(make_item(KIND_READY, ID_TOP, TIME_TOP, TIME_TOP, 1'b0, '0, 1'b1));
    send_beat(make_item(KIND_UNREADY, '0, '0, '0, 1'b1, '0, 1'b1));
    send_beat(make_item(KIND_REMOVE, 5'd5, '0, '0, 1'b0, '0, 1'b1));
    for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++) begin
      send_beat(make_item(KIND_BITS'(k), 5'd7, '0, '0, 1'b0, 5'd7, 1'b1));
    end
  endtask

  task automatic test_registration();
    send_beat(make_item(KIND_REGISTER, '0, '0, '0, 1'b0, '0, 1'b1));
    send_beat(make_item(KIND_REGISTER, '0, '0, '0, 1'b0, '0, 1'b1));
    send_beat(make_item(KIND_REGISTER, ID_TOP, '0, '0, 1'b0, '0, 1'b1));
    send_beat(make_item(KIND_READY, ID_TOP, TIME_TOP, TIME_TOP, 1'b0, '0, 1'b1));
    send_beat(make_item(KIND_READY, '0, '0, '0, 1'b0, '0, 1'b1));
    send_beat(make_item(KIND_READY, '0, 48'd50, 48'd100, 1'b0, '0, 1'b1));
    send_beat(make_item(KIND_UNREADY, '0, '0, '0, 1'b0, '0, 1'b1));
    send_beat(make_item(KIND_UNREADY, '0, '0, '0, 1'b1, '0, 1'b1));
    send_beat(make_item(KIND_READY, '0, 48'd10, 48'd10, 1'b0, '0, 1'b1));
  endtask

  task automatic test_preempt();
    send_beat(make_item(KIND_REGISTER, 5'd3, '0, '0, 1'b0, '0, 1'b1));
    send_beat(make_item(KIND_REGISTER, 5'd4, '0, '0, 1'b0, '0, 1'b1));
    send_beat(make_item(KIND_READY, 5'd3, '0, 48'd1000, 1'b0, '0, 1'b1));
    send_beat(make_item(KIND_READY, 5'd4, 48'd1000, '0, 1'b0, '0, 1'b1));
    send_beat(make_item(KIND_QUERY, '0, '0, '0, 1'b0, 5'd4, 1'b1));
    send_beat(make_item(KIND_QUERY, '0, '0, '0, 1'b0, ID_TOP, 1'b1));
    send_beat(make_item(KIND_REMOVE, ID_TOP, '0, '0, 1'b0, '0, 1'b1));
    send_beat(make_item(KIND_QUERY, '0, '0, '0, 1'b0, ID_TOP, 1'b1));
  endtask

  task automatic test_random_traffic(input int beats);
    sim_now = TIME_BITS'({$urandom, $urandom}) >> 2;
    for (int n = 0; n < beats; n++) begin
      if (n > 0 && n % DRAIN_EVERY == 0) begin
        wait_drained();
      end
      if (n % STRETCH_BEATS == 0) begin
        idle_on = ($urandom_range(0, 3) != 0);
      end
      send_beat(random_item());
    end
    idle_on = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", TIME_BITS'(out_item), '0);
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_item.status !== oldest_result.status)
          report_mismatch("status", TIME_BITS'(out_item.status),
                          TIME_BITS'(oldest_result.status));
        if (out_item.next_valid !== oldest_result.next_valid)
          report_mismatch("next_valid", TIME_BITS'(out_item.next_valid),
                          TIME_BITS'(oldest_result.next_valid));
        if (out_item.next_task !== oldest_result.next_task)
          report_mismatch("next_task", TIME_BITS'(out_item.next_task),
                          TIME_BITS'(oldest_result.next_task));
        if (out_item.preempt !== oldest_result.preempt)
          report_mismatch("preempt", TIME_BITS'(out_item.preempt),
                          TIME_BITS'(oldest_result.preempt));
        if (out_item.ready_count !== oldest_result.ready_count)
          report_mismatch("ready_count", TIME_BITS'(out_item.ready_count),
                          TIME_BITS'(oldest_result.ready_count));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_edf_task_scheduler: FAIL");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < TASK_SLOTS; i++) begin
      task_known[i]    = 1'b0;
      task_ready[i]    = 1'b0;
      task_deadline[i] = '0;
    end
    ready_tasks = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_registration();
    test_preempt();
    test_random_traffic(RANDOM_BEATS);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_edf_task_scheduler: PASS");
    end else begin
      $display("tb_edf_task_scheduler: FAIL");
    end
    $finish;
  end

endmodule
